// File: design/circle_elastic_collision_macros.svh
// Assertion macros for the disc collision block.
// Used by the checker; needs clk and arst_n in the enclosing scope.
`ifndef CIRCLE_ELASTIC_COLLISION_MACROS_SVH
`define CIRCLE_ELASTIC_COLLISION_MACROS_SVH

// antecedent implies consequent on the same edge
`define CEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition never seen at any edge
`define CEC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: design/cec_pkg.sv
// Shared types and constants of the disc collision pipeline.
// No dependencies.
package cec_pkg;

	localparam int LATENCY    = 104;
	localparam int SQRT_STEPS = 21;
	localparam int QW_A       = 22;
	localparam int QW_B       = 23;
	localparam int QW_C       = 23;

	localparam logic [7:0] CONTACT_MARGIN_RST = 8'd3;
	localparam logic [7:0] MIN_SEPARATION_RST = 8'd26;

	typedef enum logic {
		CFG_CONTACT_MARGIN = 1'b0,
		CFG_MIN_SEPARATION = 1'b1
	} cfg_idx_t;

	// per-word context carried down the pipeline
	typedef struct packed {
		logic signed [19:0] p1x;
		logic signed [19:0] p1y;
		logic signed [19:0] v1x;
		logic signed [19:0] v1y;
		logic signed [19:0] p2x;
		logic signed [19:0] p2y;
		logic signed [19:0] v2x;
		logic signed [19:0] v2y;
		logic [15:0]        r1;
		logic [15:0]        r2;
		logic signed [20:0] dx;
		logic signed [20:0] dy;
		logic [31:0]        m1;
		logic [31:0]        m2;
		logic [32:0]        mt;
		logic [16:0]        sumr;
		logic               zero;
		logic               hit;
		logic               close;
		logic [16:0]        dk;
		logic [16:0]        depth;
		logic signed [20:0] dvx;
		logic signed [20:0] dvy;
		logic signed [23:0] dp1x;
		logic signed [23:0] dp1y;
		logic signed [23:0] dp2x;
		logic signed [23:0] dp2y;
	} ctx_t;

	function automatic logic signed [19:0] sat20(input logic signed [25:0] v);
		if (v > 26'sd524287)
			return 20'sd524287;
		if (v < -26'sd524288)
			return -20'sd524288;
		return v[19:0];
	endfunction

endpackage

// File: design/cec_div.sv
// Pipelined signed divider, round to nearest with ties away from zero.
// One quotient bit per stage, between input and output registers. No dependencies.
module cec_div #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int QW = 22
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [QW:0]   quot
);
	localparam int RW = DW + 1;

	logic [NW-1:0]      absn_c;
	logic [NW-1:0]      mag_c;
	logic [NW-1:0]      mag_s [QW+1];
	logic [DW-1:0]      den_s [QW+1];
	logic               neg_s [QW+1];
	logic [RW-1:0]      rem_s [QW+1];
	logic [QW-1:0]      q_s   [QW+1];
	logic signed [QW:0] quot_q;

	// magnitude plus half the divisor gives the rounding
	always_comb begin
		absn_c = num[NW-1] ? NW'(-num) : NW'(num);
		mag_c  = absn_c + NW'(den >> 1);
	end

	always_ff @(posedge clk) begin
		mag_s[0] <= mag_c;
		den_s[0] <= den;
		neg_s[0] <= num[NW-1];
		rem_s[0] <= RW'(mag_c >> QW);
		q_s[0]   <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;
		always_comb begin
			trial = {rem_s[k][DW-1:0], mag_s[k][QW-1-k]};
			ge    = trial >= {1'b0, den_s[k]};
		end
		always_ff @(posedge clk) begin
			mag_s[k+1] <= mag_s[k];
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			rem_s[k+1] <= ge ? trial - {1'b0, den_s[k]} : trial;
			q_s[k+1]   <= {q_s[k][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= neg_s[QW] ? -signed'({1'b0, q_s[QW]}) : signed'({1'b0, q_s[QW]});
	end

	assign quot = quot_q;

endmodule

// File: design/circle_elastic_collision.sv
// Top level of the two-disc elastic collision pipeline.
// Depends on cec_pkg and cec_div.
//
// Usage:
//  - Input word: both discs (centre, velocity in signed Q12.8, radius in
//    unsigned Q8.8) on their own ports; taken at an edge with start high
//    and busy low. busy is always low: a new word can enter every cycle.
//  - Result word: eight saturated Q12.8 values and collided, shown for
//    exactly one cycle with done high. Results leave in input order.
//  - Throughput is one word per cycle. The pipe depth is set by the
//    21-step square root and three levels of bit-per-stage dividers
//    (22, 23 and 23 quotient bits) with multiply stages in between.
//  - Config: cfg_we/cfg_index/cfg_data write contact_margin (index 0) or
//    min_separation (index 1). Write only while the pipe is
//    empty; words in flight read the registers late in the pipe.
//  - Reset (arst_n low) clears the valid line and loads the register
//    defaults (margin 3, min separation 26). Words in flight are dropped.
//  - There is no backpressure: the receiver must take each result word
//    in its done cycle.
module circle_elastic_collision (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic signed [19:0] first_pos_x,
	input  logic signed [19:0] first_pos_y,
	input  logic signed [19:0] first_vel_x,
	input  logic signed [19:0] first_vel_y,
	input  logic [15:0]        first_radius,
	input  logic signed [19:0] second_pos_x,
	input  logic signed [19:0] second_pos_y,
	input  logic signed [19:0] second_vel_x,
	input  logic signed [19:0] second_vel_y,
	input  logic [15:0]        second_radius,
	output logic               done,
	output logic signed [19:0] new_first_pos_x,
	output logic signed [19:0] new_first_pos_y,
	output logic signed [19:0] new_first_vel_x,
	output logic signed [19:0] new_first_vel_y,
	output logic signed [19:0] new_second_pos_x,
	output logic signed [19:0] new_second_pos_y,
	output logic signed [19:0] new_second_vel_x,
	output logic signed [19:0] new_second_vel_y,
	output logic               collided
);
	import cec_pkg::*;

	// ---------------------------------------------------------------
	// Config registers and valid line
	// ---------------------------------------------------------------
	logic [7:0]         contact_margin_q;
	logic [7:0]         min_separation_q;
	logic [LATENCY-1:0] vld_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_margin_q <= CONTACT_MARGIN_RST;
			min_separation_q <= MIN_SEPARATION_RST;
			vld_q            <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CONTACT_MARGIN: contact_margin_q <= cfg_data;
					CFG_MIN_SEPARATION: min_separation_q <= cfg_data;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// s1: capture, centre difference
	// ---------------------------------------------------------------
	ctx_t c_in, c_s1;

	always_comb begin
		c_in     = '0;
		c_in.p1x = first_pos_x;
		c_in.p1y = first_pos_y;
		c_in.v1x = first_vel_x;
		c_in.v1y = first_vel_y;
		c_in.r1  = first_radius;
		c_in.p2x = second_pos_x;
		c_in.p2y = second_pos_y;
		c_in.v2x = second_vel_x;
		c_in.v2y = second_vel_y;
		c_in.r2  = second_radius;
		c_in.dx  = 21'(second_pos_x) - 21'(first_pos_x);
		c_in.dy  = 21'(second_pos_y) - 21'(first_pos_y);
	end

	always_ff @(posedge clk) begin
		c_s1 <= c_in;
	end

	// ---------------------------------------------------------------
	// s2: squares of the difference, masses, radius sum
	// ---------------------------------------------------------------
	ctx_t        n2, c_s2;
	logic [40:0] sqx_s2, sqy_s2;

	always_comb begin
		n2      = c_s1;
		n2.m1   = c_s1.r1 * c_s1.r1;
		n2.m2   = c_s1.r2 * c_s1.r2;
		n2.sumr = 17'(c_s1.r1) + 17'(c_s1.r2);
	end

	always_ff @(posedge clk) begin
		c_s2   <= n2;
		sqx_s2 <= 41'(c_s1.dx * c_s1.dx);
		sqy_s2 <= 41'(c_s1.dy * c_s1.dy);
	end

	// ---------------------------------------------------------------
	// s3..s24: squared distance, then integer square root, 2 bits/stage
	// ---------------------------------------------------------------
	ctx_t        n3;
	ctx_t        sq_c_s    [SQRT_STEPS+1];
	logic [41:0] sq_d2_s   [SQRT_STEPS+1];
	logic [22:0] sq_rem_s  [SQRT_STEPS+1];
	logic [20:0] sq_root_s [SQRT_STEPS+1];

	always_comb begin
		n3      = c_s2;
		n3.mt   = 33'(c_s2.m1) + 33'(c_s2.m2);
		n3.zero = (c_s2.dx == 21'sd0) && (c_s2.dy == 21'sd0);
	end

	always_ff @(posedge clk) begin
		sq_c_s[0]    <= n3;
		sq_d2_s[0]   <= 42'(sqx_s2) + 42'(sqy_s2);
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [22:0] cand;
		logic [22:0] trial;
		logic        ge;
		always_comb begin
			cand  = {sq_rem_s[k][20:0], sq_d2_s[k][41-2*k -: 2]};
			trial = {sq_root_s[k], 2'b01};
			ge    = cand >= trial;
		end
		always_ff @(posedge clk) begin
			sq_c_s[k+1]    <= sq_c_s[k];
			sq_d2_s[k+1]   <= sq_d2_s[k];
			sq_rem_s[k+1]  <= ge ? cand - trial : cand;
			sq_root_s[k+1] <= {sq_root_s[k][19:0], ge};
		end
	end

	// ---------------------------------------------------------------
	// s25: contact test, overlap depth, relative velocity
	// ---------------------------------------------------------------
	ctx_t        n25, c_s25;
	logic [20:0] root_c;

	always_comb begin
		root_c    = sq_root_s[SQRT_STEPS];
		n25       = sq_c_s[SQRT_STEPS];
		n25.hit   = (22'(root_c) + 22'(contact_margin_q)) < 22'(n25.sumr);
		n25.close = root_c > 21'(min_separation_q);
		// distance fits 17 bits whenever the pair is in contact
		n25.dk    = root_c[16:0];
		n25.depth = n25.sumr - root_c[16:0];
		n25.dvx   = 21'(n25.v2x) - 21'(n25.v1x);
		n25.dvy   = 21'(n25.v2y) - 21'(n25.v1y);
	end

	always_ff @(posedge clk) begin
		c_s25 <= n25;
	end

	// ---------------------------------------------------------------
	// s26: share and dot products; s27: dot sum
	// ---------------------------------------------------------------
	ctx_t               c_s26, c_s27;
	logic [48:0]        pm1_s26, pm2_s26, pm1_s27, pm2_s27;
	logic signed [41:0] pdx_s26, pdy_s26;
	logic signed [42:0] dot_s27;

	always_ff @(posedge clk) begin
		c_s26   <= c_s25;
		pm1_s26 <= c_s25.depth * c_s25.m1;
		pm2_s26 <= c_s25.depth * c_s25.m2;
		pdx_s26 <= c_s25.dvx * c_s25.dx;
		pdy_s26 <= c_s25.dvy * c_s25.dy;
		c_s27   <= c_s26;
		pm1_s27 <= pm1_s26;
		pm2_s27 <= pm2_s26;
		dot_s27 <= 43'(pdx_s26) + 43'(pdy_s26);
	end

	// ---------------------------------------------------------------
	// Divide level A (s28..s51): mass shares and normal speed
	// ---------------------------------------------------------------
	logic signed [QW_A:0] sh1_s51, sh2_s51, rn_s51;
	ctx_t                 wa_s [QW_A+2];

	cec_div #(.NW(50), .DW(33), .QW(QW_A)) u_div_sh1 (
		.clk (clk), .num (signed'({1'b0, pm1_s27})), .den (c_s27.mt), .quot (sh1_s51));
	cec_div #(.NW(50), .DW(33), .QW(QW_A)) u_div_sh2 (
		.clk (clk), .num (signed'({1'b0, pm2_s27})), .den (c_s27.mt), .quot (sh2_s51));
	cec_div #(.NW(43), .DW(17), .QW(QW_A)) u_div_rn (
		.clk (clk), .num (dot_s27), .den (c_s27.dk), .quot (rn_s51));

	always_ff @(posedge clk) begin
		wa_s[0] <= c_s27;
		for (int j = 1; j < QW_A + 2; j++)
			wa_s[j] <= wa_s[j-1];
	end

	// ---------------------------------------------------------------
	// s52: numerators of position shifts and velocity gains
	// ---------------------------------------------------------------
	ctx_t               c_s52;
	logic signed [17:0] sh1_m, sh2_m;
	logic signed [33:0] m1x2, m2x2;
	logic signed [39:0] ps1x_s52, ps1y_s52, ps2x_s52, ps2y_s52;
	logic signed [56:0] km1_s52, km2_s52;

	always_comb begin
		// shares never exceed the overlap depth
		sh1_m = signed'({1'b0, sh1_s51[16:0]});
		sh2_m = signed'({1'b0, sh2_s51[16:0]});
		m1x2  = signed'({1'b0, wa_s[QW_A+1].m1, 1'b0});
		m2x2  = signed'({1'b0, wa_s[QW_A+1].m2, 1'b0});
	end

	always_ff @(posedge clk) begin
		c_s52    <= wa_s[QW_A+1];
		ps2x_s52 <= sh2_m * wa_s[QW_A+1].dx;
		ps2y_s52 <= sh2_m * wa_s[QW_A+1].dy;
		ps1x_s52 <= sh1_m * wa_s[QW_A+1].dx;
		ps1y_s52 <= sh1_m * wa_s[QW_A+1].dy;
		km2_s52  <= m2x2 * rn_s51;
		km1_s52  <= m1x2 * rn_s51;
	end

	// ---------------------------------------------------------------
	// Divide level B (s53..s77): position shifts and gains k1, k2
	// ---------------------------------------------------------------
	logic signed [QW_B:0] dp1x_s77, dp1y_s77, dp2x_s77, dp2y_s77;
	logic signed [QW_B:0] k1_s77, k2_s77;
	ctx_t                 wb_s [QW_B+2];

	cec_div #(.NW(40), .DW(17), .QW(QW_B)) u_div_dp1x (
		.clk (clk), .num (ps2x_s52), .den (c_s52.dk), .quot (dp1x_s77));
	cec_div #(.NW(40), .DW(17), .QW(QW_B)) u_div_dp1y (
		.clk (clk), .num (ps2y_s52), .den (c_s52.dk), .quot (dp1y_s77));
	cec_div #(.NW(40), .DW(17), .QW(QW_B)) u_div_dp2x (
		.clk (clk), .num (ps1x_s52), .den (c_s52.dk), .quot (dp2x_s77));
	cec_div #(.NW(40), .DW(17), .QW(QW_B)) u_div_dp2y (
		.clk (clk), .num (ps1y_s52), .den (c_s52.dk), .quot (dp2y_s77));
	cec_div #(.NW(57), .DW(33), .QW(QW_B)) u_div_k1 (
		.clk (clk), .num (km2_s52), .den (c_s52.mt), .quot (k1_s77));
	cec_div #(.NW(57), .DW(33), .QW(QW_B)) u_div_k2 (
		.clk (clk), .num (km1_s52), .den (c_s52.mt), .quot (k2_s77));

	always_ff @(posedge clk) begin
		wb_s[0] <= c_s52;
		for (int j = 1; j < QW_B + 2; j++)
			wb_s[j] <= wb_s[j-1];
	end

	// ---------------------------------------------------------------
	// s78: keep position shifts, velocity numerators
	// ---------------------------------------------------------------
	ctx_t               n78, c_s78;
	logic signed [44:0] pk1x_s78, pk1y_s78, pk2x_s78, pk2y_s78;

	always_comb begin
		n78      = wb_s[QW_B+1];
		n78.dp1x = dp1x_s77;
		n78.dp1y = dp1y_s77;
		n78.dp2x = dp2x_s77;
		n78.dp2y = dp2y_s77;
	end

	always_ff @(posedge clk) begin
		c_s78    <= n78;
		pk1x_s78 <= k1_s77 * wb_s[QW_B+1].dx;
		pk1y_s78 <= k1_s77 * wb_s[QW_B+1].dy;
		pk2x_s78 <= k2_s77 * wb_s[QW_B+1].dx;
		pk2y_s78 <= k2_s77 * wb_s[QW_B+1].dy;
	end

	// ---------------------------------------------------------------
	// Divide level C (s79..s103): velocity changes
	// ---------------------------------------------------------------
	logic signed [QW_C:0] dv1x_s103, dv1y_s103, dv2x_s103, dv2y_s103;
	ctx_t                 wc_s [QW_C+2];

	cec_div #(.NW(45), .DW(17), .QW(QW_C)) u_div_dv1x (
		.clk (clk), .num (pk1x_s78), .den (c_s78.dk), .quot (dv1x_s103));
	cec_div #(.NW(45), .DW(17), .QW(QW_C)) u_div_dv1y (
		.clk (clk), .num (pk1y_s78), .den (c_s78.dk), .quot (dv1y_s103));
	cec_div #(.NW(45), .DW(17), .QW(QW_C)) u_div_dv2x (
		.clk (clk), .num (pk2x_s78), .den (c_s78.dk), .quot (dv2x_s103));
	cec_div #(.NW(45), .DW(17), .QW(QW_C)) u_div_dv2y (
		.clk (clk), .num (pk2y_s78), .den (c_s78.dk), .quot (dv2y_s103));

	always_ff @(posedge clk) begin
		wc_s[0] <= c_s78;
		for (int j = 1; j < QW_C + 2; j++)
			wc_s[j] <= wc_s[j-1];
	end

	// ---------------------------------------------------------------
	// s104: select, apply and saturate; output register
	// ---------------------------------------------------------------
	ctx_t               cf;
	logic signed [19:0] p1x_n, p1y_n, v1x_n, v1y_n, p2x_n, p2y_n, v2x_n, v2y_n;
	logic signed [19:0] p1x_s104, p1y_s104, v1x_s104, v1y_s104;
	logic signed [19:0] p2x_s104, p2y_s104, v2x_s104, v2y_s104;
	logic               hit_s104;

	always_comb begin
		cf    = wc_s[QW_C+1];
		p1x_n = cf.p1x;
		p1y_n = cf.p1y;
		v1x_n = cf.v1x;
		v1y_n = cf.v1y;
		p2x_n = cf.p2x;
		p2y_n = cf.p2y;
		v2x_n = cf.v2x;
		v2y_n = cf.v2y;
		if (cf.hit && cf.zero) begin
			// coincident centres: no normal, both discs stop
			v1x_n = '0;
			v1y_n = '0;
			v2x_n = '0;
			v2y_n = '0;
		end else if (cf.hit) begin
			if (cf.close) begin
				p1x_n = sat20(26'(cf.p1x) - 26'(cf.dp1x));
				p1y_n = sat20(26'(cf.p1y) - 26'(cf.dp1y));
				p2x_n = sat20(26'(cf.p2x) + 26'(cf.dp2x));
				p2y_n = sat20(26'(cf.p2y) + 26'(cf.dp2y));
			end
			v1x_n = sat20(26'(cf.v1x) + 26'(dv1x_s103));
			v1y_n = sat20(26'(cf.v1y) + 26'(dv1y_s103));
			v2x_n = sat20(26'(cf.v2x) - 26'(dv2x_s103));
			v2y_n = sat20(26'(cf.v2y) - 26'(dv2y_s103));
		end
	end

	always_ff @(posedge clk) begin
		p1x_s104 <= p1x_n;
		p1y_s104 <= p1y_n;
		v1x_s104 <= v1x_n;
		v1y_s104 <= v1y_n;
		p2x_s104 <= p2x_n;
		p2y_s104 <= p2y_n;
		v2x_s104 <= v2x_n;
		v2y_s104 <= v2y_n;
		hit_s104 <= cf.hit;
	end

	assign done             = vld_q[LATENCY-1];
	assign collided         = done & hit_s104;
	assign new_first_pos_x  = p1x_s104;
	assign new_first_pos_y  = p1y_s104;
	assign new_first_vel_x  = v1x_s104;
	assign new_first_vel_y  = v1y_s104;
	assign new_second_pos_x = p2x_s104;
	assign new_second_pos_y = p2y_s104;
	assign new_second_vel_x = v2x_s104;
	assign new_second_vel_y = v2y_s104;

endmodule

// File: design/cec_checker.sv
// Port-level checks of the disc collision block, bound to its top level.
// Depends on cec_pkg and circle_elastic_collision_macros.svh.
`include "circle_elastic_collision_macros.svh"
module cec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               collided,
	input logic signed [19:0] first_pos_x,
	input logic signed [19:0] first_pos_y,
	input logic signed [19:0] second_pos_x,
	input logic signed [19:0] second_pos_y,
	input logic signed [19:0] second_vel_y,
	input logic signed [19:0] new_first_pos_x,
	input logic signed [19:0] new_first_vel_x,
	input logic signed [19:0] new_second_vel_y
);
	import cec_pkg::*;

	`CEC_ASSERT_IMP(a_done_from_word, done, $past(start, LATENCY) && !$past(busy, LATENCY), "result word without an accepted word")
	`CEC_ASSERT_NEVER(a_collided_strobed, collided && !done, "collided outside a result cycle")
	`CEC_ASSERT_IMP(a_pass_through, done && !collided, (new_first_pos_x == $past(first_pos_x, LATENCY)) && (new_second_vel_y == $past(second_vel_y, LATENCY)), "miss did not pass through")
	`CEC_ASSERT_IMP(a_coincident_stop, done && collided && $past((first_pos_x == second_pos_x) && (first_pos_y == second_pos_y), LATENCY), (new_first_vel_x == 20'sd0) && (new_second_vel_y == 20'sd0) && (new_first_pos_x == $past(first_pos_x, LATENCY)), "coincident pair not stopped")

endmodule

bind circle_elastic_collision cec_checker u_cec_checker (.*);
